/* hw/rtl/nmea_rmc_pkg.sv */
// ----------------------------------------------------------------------------
// NMEA RMC time parser package
// Character codes, phase encoding, outcome codes and digit helpers.
// ----------------------------------------------------------------------------
package nmea_rmc_pkg;

  localparam int unsigned PrefixLen  = 7;
  localparam int unsigned DateCommas = 7;

  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_V      = 8'h56;
  localparam logic [7:0] CHAR_B      = 8'h42;
  localparam logic [7:0] CHAR_QMARK  = 8'h3F;

  localparam logic [11:0] YEAR_BASE  = 12'd2000;

  localparam logic [2:0] OUTCOME_A       = 3'd0;
  localparam logic [2:0] OUTCOME_V       = 3'd1;
  localparam logic [2:0] OUTCOME_OTHER   = 3'd2;
  localparam logic [2:0] OUTCOME_BAD     = 3'd3;
  localparam logic [2:0] OUTCOME_NO_DATE = 3'd4;

  typedef enum logic [8:0] {
    PH_PREFIX = 9'b000000001,
    PH_TIME   = 9'b000000010,
    PH_SEEK   = 9'b000000100,
    PH_STATUS = 9'b000001000,
    PH_COMMAS = 9'b000010000,
    PH_DATE   = 9'b000100000,
    PH_DONE   = 9'b001000000,
    PH_BAD    = 9'b010000000,
    PH_SKIP   = 9'b100000000
  } parse_phase_e;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      3'd6:    c = CHAR_COMMA;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Tens digit replaces the register, units digit adds to it.
  function automatic logic [6:0] put_digit(input logic [6:0] r, input logic [3:0] d,
                                           input logic units);
    logic [6:0] d7;
    d7 = {3'b000, d};
    if (units) begin
      return r + d7;
    end
    return (d7 << 3) + (d7 << 1);
  endfunction

endpackage

/* hw/rtl/nmea_rmc_time_parser.sv */
// ----------------------------------------------------------------------------
// NMEA RMC time parser
// Scans a byte stream for RMC lines and reports time, status and date at the
// newline ending each such line whose time parses and status field is reached.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// rx        in   rx_valid_i/rx_ready_o  rx_byte_i
// res       out  res_valid_o/res_ready_i outcome_o, status_char_o, hour_o,
//                                       minute_o, second_o, day_o, month_o,
//                                       year_o
//
// One byte per cycle while rx_ready_o is high: the parse state updates in the cycle a byte is taken.
// A result appears in the output register the cycle after its newline.
// rx_ready_o stays high while the output register is empty or being drained.
// Reset returns the parser to the start of a line with status '?'.
// ----------------------------------------------------------------------------
module nmea_rmc_time_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [2:0]  outcome_o,
  output logic [7:0]  status_char_o,
  output logic [6:0]  hour_o,
  output logic [6:0]  minute_o,
  output logic [6:0]  second_o,
  output logic [6:0]  day_o,
  output logic [6:0]  month_o,
  output logic [11:0] year_o
);

  nmea_rmc_pkg::parse_phase_e phase_q, phase_d;
  logic [2:0] prefix_idx_q, prefix_idx_d;
  logic [2:0] digit_cnt_q, digit_cnt_d;
  logic [2:0] comma_cnt_q, comma_cnt_d;
  logic [6:0] hour_q, hour_d, minute_q, minute_d, second_q, second_d;
  logic [6:0] day_q, day_d, month_q, month_d, year_q, year_d;
  logic [7:0] status_q, status_d;

  logic        res_valid_q;
  logic [2:0]  res_outcome_q;
  logic [7:0]  res_status_q;
  logic [6:0]  res_hour_q, res_minute_q, res_second_q, res_day_q, res_month_q;
  logic [11:0] res_year_q;

  logic        rx_fire;
  logic        is_nl;
  logic        emit;
  logic        dated;
  logic [2:0]  outcome_d;
  logic [3:0]  digit_val;

  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;
  assign is_nl      = (rx_byte_i == nmea_rmc_pkg::CHAR_NL);
  assign digit_val  = rx_byte_i[3:0];

  always_comb begin
    phase_d      = phase_q;
    prefix_idx_d = prefix_idx_q;
    digit_cnt_d  = digit_cnt_q;
    comma_cnt_d  = comma_cnt_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    second_d     = second_q;
    day_d        = day_q;
    month_d      = month_q;
    year_d       = year_q;
    status_d     = status_q;
    emit         = 1'b0;
    dated        = 1'b0;
    outcome_d    = nmea_rmc_pkg::OUTCOME_NO_DATE;

    if (is_nl) begin
      case (phase_q)
        nmea_rmc_pkg::PH_STATUS: begin
          emit     = 1'b1;
          status_d = nmea_rmc_pkg::CHAR_NL;
        end
        nmea_rmc_pkg::PH_COMMAS: begin
          emit = 1'b1;
        end
        nmea_rmc_pkg::PH_DATE, nmea_rmc_pkg::PH_BAD: begin
          emit      = 1'b1;
          status_d  = nmea_rmc_pkg::CHAR_B;
          outcome_d = nmea_rmc_pkg::OUTCOME_BAD;
        end
        nmea_rmc_pkg::PH_DONE: begin
          emit  = 1'b1;
          dated = 1'b1;
          if (status_q == nmea_rmc_pkg::CHAR_A) begin
            outcome_d = nmea_rmc_pkg::OUTCOME_A;
          end else if (status_q == nmea_rmc_pkg::CHAR_V) begin
            outcome_d = nmea_rmc_pkg::OUTCOME_V;
          end else begin
            outcome_d = nmea_rmc_pkg::OUTCOME_OTHER;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      phase_d      = nmea_rmc_pkg::PH_PREFIX;
      prefix_idx_d = '0;
      digit_cnt_d  = '0;
      comma_cnt_d  = '0;
    end else begin
      case (phase_q)
        nmea_rmc_pkg::PH_PREFIX: begin
          if (rx_byte_i == nmea_rmc_pkg::prefix_char(prefix_idx_q)) begin
            prefix_idx_d = prefix_idx_q + 3'd1;
            if (prefix_idx_q == 3'(nmea_rmc_pkg::PrefixLen - 1)) begin
              phase_d     = nmea_rmc_pkg::PH_TIME;
              digit_cnt_d = '0;
            end
          end else begin
            phase_d = nmea_rmc_pkg::PH_SKIP;
          end
        end
        nmea_rmc_pkg::PH_TIME: begin
          if (nmea_rmc_pkg::is_digit(rx_byte_i)) begin
            case (digit_cnt_q[2:1])
              2'd0:    hour_d   = nmea_rmc_pkg::put_digit(hour_q, digit_val, digit_cnt_q[0]);
              2'd1:    minute_d = nmea_rmc_pkg::put_digit(minute_q, digit_val, digit_cnt_q[0]);
              default: second_d = nmea_rmc_pkg::put_digit(second_q, digit_val, digit_cnt_q[0]);
            endcase
            digit_cnt_d = digit_cnt_q + 3'd1;
            if (digit_cnt_q == 3'd5) begin
              phase_d = nmea_rmc_pkg::PH_SEEK;
            end
          end else begin
            phase_d = nmea_rmc_pkg::PH_SKIP;
          end
        end
        nmea_rmc_pkg::PH_SEEK: begin
          if (rx_byte_i == nmea_rmc_pkg::CHAR_COMMA) begin
            phase_d = nmea_rmc_pkg::PH_STATUS;
          end
        end
        nmea_rmc_pkg::PH_STATUS: begin
          status_d    = rx_byte_i;
          comma_cnt_d = (rx_byte_i == nmea_rmc_pkg::CHAR_COMMA) ? 3'd1 : 3'd0;
          phase_d     = nmea_rmc_pkg::PH_COMMAS;
        end
        nmea_rmc_pkg::PH_COMMAS: begin
          if (rx_byte_i == nmea_rmc_pkg::CHAR_COMMA) begin
            comma_cnt_d = comma_cnt_q + 3'd1;
            if (comma_cnt_q == 3'(nmea_rmc_pkg::DateCommas - 1)) begin
              phase_d     = nmea_rmc_pkg::PH_DATE;
              digit_cnt_d = '0;
            end
          end
        end
        nmea_rmc_pkg::PH_DATE: begin
          if (nmea_rmc_pkg::is_digit(rx_byte_i)) begin
            case (digit_cnt_q[2:1])
              2'd0:    day_d   = nmea_rmc_pkg::put_digit(day_q, digit_val, digit_cnt_q[0]);
              2'd1:    month_d = nmea_rmc_pkg::put_digit(month_q, digit_val, digit_cnt_q[0]);
              default: year_d  = nmea_rmc_pkg::put_digit(year_q, digit_val, digit_cnt_q[0]);
            endcase
            digit_cnt_d = digit_cnt_q + 3'd1;
            if (digit_cnt_q == 3'd5) begin
              phase_d = nmea_rmc_pkg::PH_DONE;
            end
          end else begin
            phase_d = nmea_rmc_pkg::PH_BAD;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= nmea_rmc_pkg::PH_PREFIX;
      prefix_idx_q <= '0;
      digit_cnt_q  <= '0;
      comma_cnt_q  <= '0;
      hour_q       <= '0;
      minute_q     <= '0;
      second_q     <= '0;
      day_q        <= '0;
      month_q      <= '0;
      year_q       <= '0;
      status_q     <= nmea_rmc_pkg::CHAR_QMARK;
    end else if (rx_fire) begin
      phase_q      <= phase_d;
      prefix_idx_q <= prefix_idx_d;
      digit_cnt_q  <= digit_cnt_d;
      comma_cnt_q  <= comma_cnt_d;
      hour_q       <= hour_d;
      minute_q     <= minute_d;
      second_q     <= second_d;
      day_q        <= day_d;
      month_q      <= month_d;
      year_q       <= year_d;
      status_q     <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (rx_fire && emit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire && emit) begin
      res_outcome_q <= outcome_d;
      res_status_q  <= status_d;
      res_hour_q    <= hour_q;
      res_minute_q  <= minute_q;
      res_second_q  <= second_q;
      res_day_q     <= dated ? day_q : 7'd0;
      res_month_q   <= dated ? month_q : 7'd0;
      res_year_q    <= nmea_rmc_pkg::YEAR_BASE + {5'd0, (dated ? year_q : 7'd0)};
    end
  end

  assign res_valid_o   = res_valid_q;
  assign outcome_o     = res_outcome_q;
  assign status_char_o = res_status_q;
  assign hour_o        = res_hour_q;
  assign minute_o      = res_minute_q;
  assign second_o      = res_second_q;
  assign day_o         = res_day_q;
  assign month_o       = res_month_q;
  assign year_o        = res_year_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fire && is_nl |=> phase_q == nmea_rmc_pkg::PH_PREFIX && prefix_idx_q == 3'd0)
    else $error("parser not back at line start after newline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(rx_fire && is_nl))
    else $error("result raised without a newline transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (outcome_o == nmea_rmc_pkg::OUTCOME_BAD ||
                    outcome_o == nmea_rmc_pkg::OUTCOME_NO_DATE)
    |-> day_o == 7'd0 && month_o == 7'd0 && year_o == nmea_rmc_pkg::YEAR_BASE)
    else $error("undated result carries date fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && outcome_o == nmea_rmc_pkg::OUTCOME_BAD
    |-> status_char_o == nmea_rmc_pkg::CHAR_B)
    else $error("bad date result without forced status");

endmodule
